### design/dilp_pkg.sv
// ----------------------------------------------------------------------------
// dilp_pkg - shared types and constants of the integer list parser
// Item structs, character class codes, configuration layout and list match.
// ----------------------------------------------------------------------------
package dilp_pkg;

    localparam int BOUNDARY_SLOTS = 4;
    localparam int IGNORE_SLOTS   = 4;
    localparam int CHAR_W         = 16;
    localparam int LIST_W         = 64;
    localparam int LIST_MAX_SLOTS = LIST_W / CHAR_W;
    localparam int MAG_W          = 32;
    localparam int PROD_W         = MAG_W + 4;   // magnitude * 10 + 9 fits
    localparam int COUNT_W        = 8;
    localparam int CFG_IDX_W      = 8;
    localparam int FIFO_DEPTH     = 2;
    localparam int FIFO_PTR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W     = $clog2(FIFO_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CH_MINUS = 16'h002D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 16'h0020;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 16'h0030;
    localparam logic [CHAR_W-1:0] CH_NINE  = 16'h0039;

    localparam logic [COUNT_W-1:0] MAX_VALUES_RST = 8'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE       = 8'd0,
        CFG_MAX_VALUES = 8'd1,
        CFG_BOUNDARY   = 8'd2,
        CFG_IGNORE     = 8'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              end_of_string;
    } t_in_item;

    typedef struct packed {
        logic signed [MAG_W-1:0] value;
        logic [COUNT_W-1:0]      slot;
        logic                    stored;
        logic                    last;
        logic [COUNT_W-1:0]      total;
        logic                    overflow;
    } t_out_item;

    typedef struct packed {
        logic               mode;
        logic [COUNT_W-1:0] max_values;
        logic [LIST_W-1:0]  boundary_chars;
        logic [LIST_W-1:0]  ignore_chars;
    } t_cfg;

    // What the back end has to do with one item
    typedef enum logic [2:0] {
        K_END,
        K_BOUND,
        K_DIGIT,
        K_MINUS,
        K_OTHER
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [3:0] digit;
        logic       is_space;
        logic       is_ignore;
    } t_class;

    // Hit in a zero-terminated list of up to four characters
    function automatic logic list_hit(input logic [CHAR_W-1:0] c,
                                      input logic [LIST_W-1:0] list,
                                      input int                slots);
        logic              alive;
        logic              hit;
        logic [CHAR_W-1:0] e;
        alive = 1'b1;
        hit   = 1'b0;
        for (int k = 0; k < LIST_MAX_SLOTS; k++) begin
            e = list[k*CHAR_W +: CHAR_W];
            if (k < slots) begin
                if (e == '0) begin
                    alive = 1'b0;
                end
                if (alive && e == c) begin
                    hit = 1'b1;
                end
            end
        end
        return hit;
    endfunction

endpackage

### design/delimited_integer_list_parser.sv
// ----------------------------------------------------------------------------
// delimited_integer_list_parser - decimal integer list parser
// Splits a 16-bit character stream into fields and emits their signed values.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) takes one character
//   per item; end_of_string set closes the string and the character is unused.
//   Output channel (o_out_valid / i_out_ready / o_out_item) gives at most one
//   result per item: one per boundary while the list has room, and always one
//   for the end item, carrying the final total.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data) is
//   always ready; index 0 mode, 1 max_values, 2 boundary list, 3 ignore list.
//   Write config only while the parser is idle.
//   Throughput: one item per cycle while results are taken, set by the single
//   multiply-by-ten accumulate in the back end. Each item is classified and
//   queued when it is accepted, then accumulated into the output register
//   when the back end pops it, which waits while the result is not taken.
//   Reset (synchronous, active low) clears the field, the count and the
//   queue; config returns to mode 0, max_values 16, empty lists.
//   When the receiver stalls the result register holds; the two-entry queue
//   fills and then o_in_ready drops until results drain.
// ----------------------------------------------------------------------------
module delimited_integer_list_parser (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // character items
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  dilp_pkg::t_in_item                i_in_item,
    // result items
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output dilp_pkg::t_out_item               o_out_item,
    // register writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [dilp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dilp_pkg::LIST_W-1:0]       i_cfg_data
);

    dilp_pkg::t_cfg   r_cfg, n_cfg;
    logic             w_q_full;
    logic             w_q_push;
    logic             w_q_pop;
    logic             w_q_valid;
    dilp_pkg::t_class w_push_cls;
    dilp_pkg::t_class w_pop_cls;

    // ---------------------------------------------------------------- config
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                dilp_pkg::CFG_MODE:       n_cfg.mode           = i_cfg_data[0];
                dilp_pkg::CFG_MAX_VALUES: n_cfg.max_values     =
                                              i_cfg_data[dilp_pkg::COUNT_W-1:0];
                dilp_pkg::CFG_BOUNDARY:   n_cfg.boundary_chars = i_cfg_data;
                dilp_pkg::CFG_IGNORE:     n_cfg.ignore_chars   = i_cfg_data;
                default:                  n_cfg                = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode           <= 1'b0;
            r_cfg.max_values     <= dilp_pkg::MAX_VALUES_RST;
            r_cfg.boundary_chars <= '0;
            r_cfg.ignore_chars   <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // ---------------------------------------------------------------- front
    // classify: end / boundary / digit / minus / other, plus list hits
    dilp_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_cfg      (r_cfg),
        .i_q_full   (w_q_full),
        .o_q_push   (w_q_push),
        .o_q_cls    (w_push_cls)
    );

    // ---------------------------------------------------------------- queue
    dilp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_cls   (w_push_cls),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_cls   (w_pop_cls)
    );

    // ---------------------------------------------------------------- back
    // field state, list count and the output register
    dilp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (w_q_valid),
        .i_q_cls     (w_pop_cls),
        .o_q_pop     (w_q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

`ifndef NO_ASSERTIONS
    // a result that does not end the string is always a stored entry
    a_nonlast_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.last) |-> o_out_item.stored)
        else $error("boundary result without a stored entry");

    // a stored entry's total is its slot plus one; an unstored one has slot 0
    a_slot_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.stored
                         ? (o_out_item.total == o_out_item.slot + 8'd1)
                         : (o_out_item.slot == '0)))
        else $error("slot and total disagree");

    // popping the queue needs an entry in it
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid)
        else $error("queue pop while empty");

    // no result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");
`endif

endmodule

### design/dilp_front.sv
// ----------------------------------------------------------------------------
// dilp_front - input handshake and character classification
// Compares each character against the lists and pushes its class to the queue.
// ----------------------------------------------------------------------------
module dilp_front (
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  dilp_pkg::t_in_item i_in_item,
    input  dilp_pkg::t_cfg    i_cfg,
    input  logic              i_q_full,
    output logic              o_q_push,
    output dilp_pkg::t_class  o_q_cls
);

    logic [dilp_pkg::CHAR_W-1:0] w_c;
    logic                        w_bound;
    logic                        w_digit;

    assign w_c        = i_in_item.character;
    assign o_in_ready = !i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full;

    assign w_bound = dilp_pkg::list_hit(w_c, i_cfg.boundary_chars, dilp_pkg::BOUNDARY_SLOTS);
    assign w_digit = (w_c >= dilp_pkg::CH_ZERO) && (w_c <= dilp_pkg::CH_NINE);

    always_comb begin
        o_q_cls.digit     = w_c[3:0];
        o_q_cls.is_space  = (w_c == dilp_pkg::CH_SPACE);
        o_q_cls.is_ignore = dilp_pkg::list_hit(w_c, i_cfg.ignore_chars,
                                               dilp_pkg::IGNORE_SLOTS);
        // boundary wins over digit, minus and space
        if (i_in_item.end_of_string) begin
            o_q_cls.kind = dilp_pkg::K_END;
        end else if (w_bound) begin
            o_q_cls.kind = dilp_pkg::K_BOUND;
        end else if (w_digit) begin
            o_q_cls.kind = dilp_pkg::K_DIGIT;
        end else if (w_c == dilp_pkg::CH_MINUS) begin
            o_q_cls.kind = dilp_pkg::K_MINUS;
        end else begin
            o_q_cls.kind = dilp_pkg::K_OTHER;
        end
    end

endmodule

### design/dilp_fifo.sv
// ----------------------------------------------------------------------------
// dilp_fifo - short class queue between front and back end
// Register-based FIFO, push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module dilp_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  dilp_pkg::t_class i_cls,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output dilp_pkg::t_class o_cls
);

    dilp_pkg::t_class r_mem [dilp_pkg::FIFO_DEPTH];
    logic [dilp_pkg::FIFO_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [dilp_pkg::FIFO_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [dilp_pkg::FIFO_CNT_W-1:0] r_count, n_count;

    localparam logic [dilp_pkg::FIFO_PTR_W-1:0] LAST_PTR =
        dilp_pkg::FIFO_PTR_W'(dilp_pkg::FIFO_DEPTH - 1);
    localparam logic [dilp_pkg::FIFO_CNT_W-1:0] FULL_CNT =
        dilp_pkg::FIFO_CNT_W'(dilp_pkg::FIFO_DEPTH);

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_cls   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cls;
        end
    end

endmodule

### design/dilp_back.sv
// ----------------------------------------------------------------------------
// dilp_back - field accumulator and result register
// Applies one class per cycle when output is free; closes fields into results.
// ----------------------------------------------------------------------------
module dilp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dilp_pkg::t_cfg     i_cfg,
    input  logic               i_q_valid,
    input  dilp_pkg::t_class   i_q_cls,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output dilp_pkg::t_out_item o_out_item
);

    logic [dilp_pkg::MAG_W-1:0]   r_mag, n_mag;
    logic                         r_neg, n_neg;
    logic                         r_stopped, n_stopped;
    logic                         r_ovf, n_ovf;
    logic [dilp_pkg::COUNT_W-1:0] r_count, n_count;
    logic                         r_out_valid, n_out_valid;
    dilp_pkg::t_out_item          r_out_item, n_out_item;

    logic [dilp_pkg::PROD_W-1:0]  w_prod;
    logic [dilp_pkg::MAG_W-1:0]   w_value;
    logic                         w_room;
    logic                         w_out_free;

    // magnitude * 8 + magnitude * 2 + digit
    assign w_prod = {1'b0, r_mag, 3'b000} + {3'b000, r_mag, 1'b0}
                  + {{(dilp_pkg::PROD_W-4){1'b0}}, i_q_cls.digit};
    assign w_value    = r_neg ? (dilp_pkg::MAG_W'(0) - r_mag) : r_mag;
    assign w_room     = (r_count < i_cfg.max_values);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_q_pop    = i_q_valid && w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_comb begin
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_stopped   = r_stopped;
        n_ovf       = r_ovf;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_item  = r_out_item;

        n_out_item.value    = $signed(w_value);
        n_out_item.slot     = w_room ? r_count : '0;
        n_out_item.stored   = w_room;
        n_out_item.last     = (i_q_cls.kind == dilp_pkg::K_END);
        n_out_item.total    = w_room ? r_count + 1'b1 : r_count;
        n_out_item.overflow = r_ovf;

        if (o_q_pop) begin
            unique case (i_q_cls.kind) inside
                dilp_pkg::K_END, dilp_pkg::K_BOUND: begin
                    if (w_room || i_q_cls.kind == dilp_pkg::K_END) begin
                        n_out_valid = 1'b1;
                    end else begin
                        n_out_item = r_out_item;
                    end
                    if (i_q_cls.kind == dilp_pkg::K_END) begin
                        n_count = '0;
                    end else if (w_room) begin
                        n_count = r_count + 1'b1;
                    end
                    n_mag     = '0;
                    n_neg     = 1'b0;
                    n_stopped = 1'b0;
                    n_ovf     = 1'b0;
                end
                dilp_pkg::K_DIGIT: begin
                    n_out_item = r_out_item;
                    if (!r_stopped) begin
                        n_mag = w_prod[dilp_pkg::MAG_W-1:0];
                        if (w_prod[dilp_pkg::PROD_W-1:dilp_pkg::MAG_W-1] != '0) begin
                            n_ovf = 1'b1;
                        end
                    end
                end
                dilp_pkg::K_MINUS, dilp_pkg::K_OTHER: begin
                    n_out_item = r_out_item;
                    if (!r_stopped) begin
                        if (i_q_cls.kind == dilp_pkg::K_MINUS && r_mag == '0) begin
                            n_neg = !r_neg;
                        end else if (!i_cfg.mode) begin
                            // strict: anything unexpected kills the field
                            if (!i_q_cls.is_space && !i_q_cls.is_ignore) begin
                                n_mag     = '0;
                                n_ovf     = 1'b0;
                                n_stopped = 1'b1;
                            end
                        end else if (r_mag != '0 && !i_q_cls.is_ignore) begin
                            n_stopped = 1'b1;
                        end
                    end
                end
                default: begin
                    n_out_item = r_out_item;
                end
            endcase
        end else begin
            n_out_item = r_out_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag       <= '0;
            r_neg       <= 1'b0;
            r_stopped   <= 1'b0;
            r_ovf       <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mag       <= n_mag;
            r_neg       <= n_neg;
            r_stopped   <= n_stopped;
            r_ovf       <= n_ovf;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
    end

endmodule
